FILE: design/fiws_pkg.sv
`timescale 1ns / 1ps

package fiws_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int TICK_BITS   = 40;
  localparam int SUM_BITS    = TICK_BITS + SLOT_BITS;
  localparam int FRAC_BITS   = 16;
  localparam int MULT_BITS   = FRAC_BITS + 1;
  localparam int PROD_BITS   = MULT_BITS + TICK_BITS;
  localparam int LO_BITS     = TICK_BITS / 2;
  localparam int HI_BITS     = TICK_BITS - LO_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_BITS  = ((TICK_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 5 * TICK_BITS + SUM_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

  localparam int ADDR_BITS = 3;
  localparam logic REG_HITCH_FRACTION = 1'b0;
  localparam logic [FRAC_BITS-1:0] HF_RESET = 16'd16384;

  typedef struct packed {
    logic                 valid;
    logic [TICK_BITS-1:0] ticks;
  } q_item_t;

  typedef struct packed {
    logic [OUT_PAD_BITS-1:0] pad;
    logic [TICK_BITS-1:0]    adjusted_interval;
    logic [SUM_BITS-1:0]     window_sum;
    logic [TICK_BITS-1:0]    window_average;
    logic [TICK_BITS-1:0]    window_max;
    logic [TICK_BITS-1:0]    window_min;
    logic [TICK_BITS-1:0]    current_interval;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_MUL,
    ST_CMP
  } back_state_t;

endpackage

FILE: design/fiws_front.sv
`timescale 1ns / 1ps

module fiws_front import fiws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_BITS-1:0] s_tdata,   // interval_ticks
  output q_item_t                 head,
  input  logic                    pop
);

  logic [TICK_BITS-1:0] slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 push;
  logic                 do_pop;

  assign s_tready   = (count != CNT_BITS'(QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign head.valid = (count != '0);
  assign head.ticks = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= s_tdata[TICK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/fiws_back.sv
`timescale 1ns / 1ps

module fiws_back import fiws_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  q_item_t                  head,
  output logic                     pop,
  input  logic [FRAC_BITS-1:0]     hitch_fraction,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tuser
);

  back_state_t state;
  back_state_t state_next;

  logic [TICK_BITS-1:0]       ring [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]      slot_written;
  logic [TICK_BITS-1:0]       rd_data;
  logic                       rd_valid;
  logic [SLOT_BITS-1:0]       rd_addr;

  logic [TICK_BITS-1:0]       cur;
  logic [SLOT_BITS-1:0]       write_slot;
  logic [SLOT_BITS-1:0]       min_slot;
  logic [SLOT_BITS-1:0]       max_slot;
  logic [TICK_BITS-1:0]       min_val;
  logic [TICK_BITS-1:0]       max_val;
  logic [SUM_BITS-1:0]        running_sum;
  logic [SLOT_BITS:0]         scan_cnt;
  logic [MULT_BITS+LO_BITS-1:0] p_lo;
  logic [MULT_BITS+HI_BITS-1:0] p_hi;
  logic                       out_valid;
  result_t                    out_data;
  logic                       out_hitch;

  logic [TICK_BITS-1:0]       entry_val;
  logic [SLOT_BITS-1:0]       scan_idx;
  logic                       rescan;
  logic                       out_free;
  logic [TICK_BITS-1:0]       avg;
  logic [MULT_BITS-1:0]       mult;
  logic [PROD_BITS-1:0]       lhs;
  logic [PROD_BITS-1:0]       rhs;
  logic                       hitch;

  assign entry_val = rd_valid ? rd_data : TICK_BITS'(1);
  assign scan_idx  = SLOT_BITS'(scan_cnt - 1'b1);
  assign rd_addr   = (state == ST_SCAN) ? scan_cnt[SLOT_BITS-1:0] : write_slot;
  assign rescan    = (min_slot == write_slot) || (max_slot == write_slot);
  assign out_free  = !out_valid || m_tready;
  assign avg       = TICK_BITS'(running_sum >> SLOT_BITS);
  assign mult      = (MULT_BITS'(1) << FRAC_BITS) - {1'b0, hitch_fraction};
  assign lhs       = (PROD_BITS'(p_hi) << LO_BITS) + PROD_BITS'(p_lo);
  assign rhs       = PROD_BITS'({avg, {FRAC_BITS{1'b0}}});
  assign hitch     = lhs > rhs;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_hitch;

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      ring[write_slot] <= cur;
    end
    rd_data  <= ring[rd_addr];
    rd_valid <= slot_written[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = rescan ? ST_SCAN : ST_MUL;
      end
      ST_SCAN: begin
        if (scan_cnt == (SLOT_BITS + 1)'(SLOT_COUNT)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      min_slot     <= '0;
      max_slot     <= '0;
      min_val      <= TICK_BITS'(1);
      max_val      <= TICK_BITS'(1);
      running_sum  <= SUM_BITS'(SLOT_COUNT);
      slot_written <= '0;
      scan_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_CMP && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_UPD: begin
          running_sum <= running_sum - SUM_BITS'(entry_val) + SUM_BITS'(cur);
          slot_written[write_slot] <= 1'b1;
          write_slot <= (write_slot == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 : write_slot + 1'b1;
          scan_cnt <= '0;
          if (!rescan) begin
            if (cur <= min_val) begin
              min_slot <= write_slot;
              min_val  <= cur;
            end
            if (cur >= max_val) begin
              max_slot <= write_slot;
              max_val  <= cur;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == (SLOT_BITS + 1)'(1)) begin
            min_slot <= scan_idx;
            min_val  <= entry_val;
            max_slot <= scan_idx;
            max_val  <= entry_val;
          end else if (scan_cnt != '0) begin
            if (entry_val < min_val) begin
              min_slot <= scan_idx;
              min_val  <= entry_val;
            end
            if (entry_val >= max_val) begin
              max_slot <= scan_idx;
              max_val  <= entry_val;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head.valid) begin
      cur <= head.ticks;
    end
    if (state == ST_MUL) begin
      p_lo <= mult * cur[LO_BITS-1:0];
      p_hi <= mult * cur[TICK_BITS-1:LO_BITS];
    end
    if (state == ST_CMP && out_free) begin
      out_data.pad               <= '0;
      out_data.current_interval  <= cur;
      out_data.window_min        <= min_val;
      out_data.window_max        <= max_val;
      out_data.window_average    <= avg;
      out_data.window_sum        <= running_sum;
      out_data.adjusted_interval <= hitch ? avg : cur;
      out_hitch                  <= hitch;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    min_val <= max_val)
    else $error("window minimum above window maximum");

  a_no_rescan_skips_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && min_slot != write_slot && max_slot != write_slot)
      |=> state == ST_MUL)
    else $error("scan entered without a tracked slot overwritten");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && out_valid && !m_tready) |=> (state == ST_CMP && out_valid))
    else $error("pending result overwritten");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt <= (SLOT_BITS + 1)'(SLOT_COUNT))
    else $error("scan counter past ring end");

endmodule

FILE: design/frame_interval_window_stats.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat contents (low bits first)
// s_*      in   tdata: interval_ticks[39:0]
// m_*      out  tdata: current, min, max, average, sum[45:0], adjusted, 2 zero bits;
//                tuser: hitch_seen
// APB      in   0x0: hitch_fraction[15:0]
//
// An item goes from queue head through update, multiply and compare to the result
// register, plus a ring scan at one slot per cycle from the single ring read port
// when a tracked slot is overwritten. A two-beat input queue keeps accepting while
// the back end scans or a result waits on m_tready. Reset is synchronous and needs
// no clearing pass: per-slot valid bits make unwritten slots read as one.

module frame_interval_window_stats import fiws_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // interval_ticks
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // current_interval, window_min, window_max,
                                              // window_average, window_sum,
                                              // adjusted_interval, zero fill
  output logic                     m_tuser,   // hitch_seen
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [FRAC_BITS-1:0] hitch_fraction;
  q_item_t              head;
  logic                 pop;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1] == REG_HITCH_FRACTION)
                  ? {{(32 - FRAC_BITS){1'b0}}, hitch_fraction} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hitch_fraction <= HF_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[ADDR_BITS-1] == REG_HITCH_FRACTION) begin
      hitch_fraction <= pwdata[FRAC_BITS-1:0];
    end
  end

  fiws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  fiws_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .hitch_fraction (hitch_fraction),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser)
  );

endmodule
